// ----- hw/rtl/i2c_register_master_macros.svh -----
// Assertion macro used by the I2C register master bus engine.
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH
// Property that must hold on every clock edge out of reset.
`define I2CRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

// ----- hw/rtl/i2crm_pkg.sv -----
// Shared types and constants for the I2C register master.
`timescale 1ns / 1ps
`default_nettype none
package i2crm_pkg;
    localparam int InWidth = 27;
    localparam int OutWidth = 16;
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_BYTE = 2'd3;
    localparam logic [1:0] CFG_ADDR = 2'd0;
    localparam logic [1:0] CFG_HALF = 2'd1;
    localparam logic [1:0] CFG_POLL = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
        PH_ACK_END, PH_WAIT_BYTE, PH_RX_HIGH, PH_RX_LOW, PH_MACK, PH_STOP
    } phase_t;

    typedef enum logic [1:0] {KIND_ADDR, KIND_REG, KIND_DATA} kind_t;

    // Input beat: opcode, reg_addr, length, wr_byte, sda_in from bit 0 up.
    typedef struct packed {
        logic       sda_in;
        logic [7:0] wr_byte;
        logic [7:0] length;
        logic [7:0] reg_addr;
        logic [1:0] opcode;
    } item_t;

    // Result beat from bit 0 up.
    typedef struct packed {
        logic       nack_seen;
        logic       done_res;
        logic       busy_res;
        logic       rd_last;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       byte_request;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } result_t;
endpackage
`default_nettype wire

// ----- hw/rtl/i2c_register_master.sv -----
// I2C register master top level: config registers, tick queue and bus engine.
// A tick beat passes through the queue and then the engine's output register to become a result beat.
// Throughput: one tick per clock; the engine's output register decides the stall.
// Bus timing is counted in ticks, half_ticks ticks per bus step (a setting of zero counts as one).
// Reset: async active low; bus idle with both lines released, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
module i2c_register_master
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [31:0] s_axis_tdata,   // opcode, reg_addr, length, wr_byte, sda_in
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // scl, sda, byte_req, rd_valid, rd_byte,
                                       // rd_last, busy, done, nack_seen
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_index,
    input  wire [7:0]  cfg_data
);
    logic [6:0] addr_reg;
    logic [7:0] half_reg, poll_reg;
    logic       q_valid, q_ready;
    i2crm_pkg::item_t q_item;
    i2crm_pkg::result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= 7'd56;
            half_reg <= 8'd8;
            poll_reg <= 8'd102;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == i2crm_pkg::CFG_ADDR) addr_reg <= cfg_data[6:0];
            if (cfg_index == i2crm_pkg::CFG_HALF) half_reg <= cfg_data;
            if (cfg_index == i2crm_pkg::CFG_POLL) poll_reg <= cfg_data;
        end
    end

    i2crm_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_item(i2crm_pkg::item_t'(s_axis_tdata[i2crm_pkg::InWidth-1:0])),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    i2crm_engine u_engine
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .dev_addr(addr_reg), .half_ticks(half_reg), .poll_limit(poll_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = res;
endmodule
`default_nettype wire

// ----- hw/rtl/i2crm_fifo.sv -----
// Two-entry queue between the input stage and the bus engine.
`timescale 1ns / 1ps
`default_nettype none
module i2crm_fifo
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire i2crm_pkg::item_t in_item,
    output logic                  out_valid,
    input  wire                   out_ready,
    output i2crm_pkg::item_t      out_item
);
    i2crm_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_item;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/i2crm_engine.sv -----
// Bus engine: one tick per item, result held in an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_master_macros.svh"
module i2crm_engine
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire i2crm_pkg::item_t in_item,
    input  wire [6:0]             dev_addr,
    input  wire [7:0]             half_ticks,
    input  wire [7:0]             poll_limit,
    output logic                  out_valid,
    input  wire                   out_ready,
    output i2crm_pkg::result_t    out_res
);
    i2crm_pkg::phase_t phase_reg, phase_next;
    i2crm_pkg::kind_t  kind_reg, kind_next;
    logic [7:0] div_reg, div_next, shift_reg, shift_next, left_reg, left_next;
    logic [7:0] poll_reg, poll_next, rlatch_reg, rlatch_next;
    logic [3:0] bit_reg, bit_next;
    logic       nack_reg, nack_next, rmode_reg, rmode_next;
    logic [1:0] line_reg, line_next, drv;
    logic [7:0] step_len;
    logic       ov_reg;
    i2crm_pkg::result_t res_reg, res_next;
    logic       go;

    assign in_ready  = !ov_reg || out_ready;
    assign go        = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign step_len  = (half_ticks == 8'd0) ? 8'd1 : half_ticks;

    always_comb
    begin
        phase_next = phase_reg; kind_next = kind_reg; div_next = div_reg;
        shift_next = shift_reg; left_next = left_reg; poll_next = poll_reg;
        rlatch_next = rlatch_reg; bit_next = bit_reg; nack_next = nack_reg;
        rmode_next = rmode_reg; line_next = line_reg; res_next = '0; drv = 2'd0;
        if (phase_reg == i2crm_pkg::PH_IDLE && (in_item.opcode == i2crm_pkg::OP_WRITE
            || in_item.opcode == i2crm_pkg::OP_READ))
        begin
            rmode_next = in_item.opcode == i2crm_pkg::OP_READ;
            left_next = in_item.length; rlatch_next = in_item.reg_addr;
            nack_next = 1'b0; poll_next = 8'd0; kind_next = i2crm_pkg::KIND_ADDR;
            shift_next = 8'd0; phase_next = i2crm_pkg::PH_START;
            bit_next = 4'd0; div_next = step_len;
        end
        else if (phase_reg == i2crm_pkg::PH_WAIT_BYTE
            && in_item.opcode == i2crm_pkg::OP_BYTE)
        begin
            shift_next = in_item.wr_byte; phase_next = i2crm_pkg::PH_TX_LOW;
            bit_next = 4'd0; div_next = step_len;
        end
        res_next.byte_request = phase_next == i2crm_pkg::PH_WAIT_BYTE;
        unique case (phase_next)
            i2crm_pkg::PH_START: drv = bit_next == 4'd0 ? 2'd0 :
                                       (bit_next == 4'd1 ? 2'd2 : 2'd3);
            i2crm_pkg::PH_TX_LOW: drv = shift_next[7] ? 2'd1 : 2'd3;
            i2crm_pkg::PH_TX_HIGH: drv = shift_next[7] ? 2'd0 : 2'd2;
            i2crm_pkg::PH_ACK_LOW, i2crm_pkg::PH_ACK_END, i2crm_pkg::PH_RX_LOW,
            i2crm_pkg::PH_WAIT_BYTE: drv = 2'd1;
            i2crm_pkg::PH_ACK_HIGH, i2crm_pkg::PH_RX_HIGH: drv = 2'd0;
            i2crm_pkg::PH_MACK: drv = {left_next > 8'd1, bit_next != 4'd1};
            i2crm_pkg::PH_STOP: drv = bit_next == 4'd0 ? 2'd3 :
                                      (bit_next == 4'd1 ? 2'd2 : 2'd0);
            default: drv = line_reg;
        endcase
        line_next = drv;
        if (phase_next != i2crm_pkg::PH_IDLE && phase_next != i2crm_pkg::PH_WAIT_BYTE)
        begin
            if (div_next > 8'd1)
                div_next = div_next - 8'd1;
            else
            begin
                div_next = step_len;
                unique case (phase_next)
                    i2crm_pkg::PH_START:
                        if (bit_next < 4'd2) bit_next = bit_next + 4'd1;
                        else
                        begin
                            shift_next = {dev_addr, rmode_next};
                            phase_next = i2crm_pkg::PH_TX_LOW; bit_next = 4'd0;
                        end
                    i2crm_pkg::PH_TX_LOW: phase_next = i2crm_pkg::PH_TX_HIGH;
                    i2crm_pkg::PH_TX_HIGH:
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                        if (bit_next >= 4'd7)
                        begin
                            phase_next = i2crm_pkg::PH_ACK_LOW; bit_next = 4'd0;
                        end
                        else
                        begin
                            phase_next = i2crm_pkg::PH_TX_LOW; bit_next = bit_next + 4'd1;
                        end
                    end
                    i2crm_pkg::PH_ACK_LOW:
                    begin
                        poll_next = 8'd0; phase_next = i2crm_pkg::PH_ACK_HIGH;
                        bit_next = 4'd0;
                    end
                    i2crm_pkg::PH_ACK_HIGH:
                        if (!in_item.sda_in) phase_next = i2crm_pkg::PH_ACK_END;
                        else if (poll_next >= poll_limit)
                        begin
                            if (kind_next != i2crm_pkg::KIND_REG) nack_next = 1'b1;
                            phase_next = i2crm_pkg::PH_ACK_END;
                        end
                        else poll_next = poll_next + 8'd1;
                    i2crm_pkg::PH_ACK_END:
                    begin
                        bit_next = 4'd0;
                        if (kind_next == i2crm_pkg::KIND_ADDR)
                        begin
                            if (!rmode_next)
                            begin
                                kind_next = i2crm_pkg::KIND_REG; shift_next = rlatch_next;
                                phase_next = i2crm_pkg::PH_TX_LOW;
                            end
                            else if (left_next == 8'd0) phase_next = i2crm_pkg::PH_STOP;
                            else
                            begin
                                shift_next = 8'd0; phase_next = i2crm_pkg::PH_RX_HIGH;
                            end
                        end
                        else if (kind_next == i2crm_pkg::KIND_REG)
                        begin
                            div_next = 8'd0;
                            if (left_next == 8'd0)
                            begin
                                phase_next = i2crm_pkg::PH_IDLE; line_next = 2'd1;
                                res_next.done_res = 1'b1;
                            end
                            else
                            begin
                                kind_next = i2crm_pkg::KIND_DATA;
                                phase_next = i2crm_pkg::PH_WAIT_BYTE;
                            end
                        end
                        else
                        begin
                            left_next = left_next - 8'd1;
                            if (left_next == 8'd0) phase_next = i2crm_pkg::PH_STOP;
                            else
                            begin
                                phase_next = i2crm_pkg::PH_WAIT_BYTE; div_next = 8'd0;
                            end
                        end
                    end
                    i2crm_pkg::PH_RX_HIGH:
                    begin
                        shift_next = {shift_next[6:0], in_item.sda_in};
                        if (bit_next >= 4'd7)
                        begin
                            res_next.rd_valid = 1'b1;
                            res_next.rd_byte = shift_next;
                            res_next.rd_last = left_next == 8'd1;
                        end
                        phase_next = i2crm_pkg::PH_RX_LOW; bit_next = bit_next + 4'd1;
                    end
                    i2crm_pkg::PH_RX_LOW:
                        if (bit_next >= 4'd8)
                        begin
                            phase_next = i2crm_pkg::PH_MACK; bit_next = 4'd0;
                        end
                        else phase_next = i2crm_pkg::PH_RX_HIGH;
                    i2crm_pkg::PH_MACK:
                        if (bit_next < 4'd2) bit_next = bit_next + 4'd1;
                        else
                        begin
                            left_next = left_next - 8'd1; bit_next = 4'd0;
                            if (left_next == 8'd0) phase_next = i2crm_pkg::PH_STOP;
                            else
                            begin
                                shift_next = 8'd0; phase_next = i2crm_pkg::PH_RX_HIGH;
                            end
                        end
                    i2crm_pkg::PH_STOP:
                        if (bit_next < 4'd2) bit_next = bit_next + 4'd1;
                        else
                        begin
                            phase_next = i2crm_pkg::PH_IDLE; bit_next = 4'd0;
                            div_next = 8'd0; line_next = 2'd0;
                            res_next.done_res = 1'b1;
                        end
                    default: ;
                endcase
            end
        end
        res_next.scl_pull_low = drv[0];
        res_next.sda_pull_low = drv[1];
        res_next.busy_res = phase_next != i2crm_pkg::PH_IDLE;
        res_next.nack_seen = res_next.done_res && nack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2crm_pkg::PH_IDLE; kind_reg <= i2crm_pkg::KIND_ADDR;
            div_reg <= 8'd0; shift_reg <= 8'd0; left_reg <= 8'd0; poll_reg <= 8'd0;
            rlatch_reg <= 8'd0; bit_reg <= 4'd0; nack_reg <= 1'b0; rmode_reg <= 1'b0;
            line_reg <= 2'd0; ov_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                phase_reg <= phase_next; kind_reg <= kind_next; div_reg <= div_next;
                shift_reg <= shift_next; left_reg <= left_next; poll_reg <= poll_next;
                rlatch_reg <= rlatch_next; bit_reg <= bit_next; nack_reg <= nack_next;
                rmode_reg <= rmode_next; line_reg <= line_next;
            end
            if (go) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) res_reg <= res_next;
    end

    `I2CRM_ASSERT(a_idle_bits, phase_reg != i2crm_pkg::PH_IDLE || bit_reg == 4'd0, "idle bit")
    `I2CRM_ASSERT(a_done_idle, !(out_valid && out_res.done_res) || !out_res.busy_res, "done busy")
    `I2CRM_ASSERT(a_rd_done, !(out_valid && out_res.rd_valid && out_res.done_res), "rd+done")
    `I2CRM_ASSERT(a_hold, (out_valid && !out_ready) |=> $stable(out_res), "hold")
endmodule
`default_nettype wire
